/* src/stf_pkg.sv */
package stf_pkg;

    // Field widths
    localparam int AMP_W      = 16;
    localparam int FRAC_W     = 4;
    localparam int TRACE_W    = 20;
    localparam int BIN_W      = 10;
    localparam int DIV_W      = 16;
    // |fresh - old| + divisor/2 stays below 2^21
    localparam int NUM_W      = 21;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TRACE_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POINTS     = 2'd1;

    // Trace modes
    localparam logic [2:0] MODE_CLEAR_WRITE = 3'd0;
    localparam logic [2:0] MODE_VIEW        = 3'd1;
    localparam logic [2:0] MODE_MAX_HOLD    = 3'd2;
    localparam logic [2:0] MODE_MIN_HOLD    = 3'd3;
    localparam logic [2:0] MODE_AVERAGE     = 3'd4;

    // Per-bin action decided by the front end
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_PASS,
        OP_VIEW,
        OP_MAX,
        OP_MIN,
        OP_AVG
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             last;
        logic [DIV_W-1:0] divisor;
    } item_ctl_t;

endpackage

/* src/spectrum_trace_accumulator.sv */
// Each bin passes a two-entry queue; the back end pops it and reads the trace store, works
// out the result, runs its bit-serial divider (21 steps) in average mode with a trace present,
// and loads the result register, waiting while the output is stalled. The back end's
// read-modify-write takes one bin at a time: a new bin leaves the queue once the last is loaded.
// Reset: mode clear write, 1024 points, no trace present, position and frame count zero;
// the trace store is not cleared; the user must write entries before they are read, the block does not check.
module spectrum_trace_accumulator #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [stf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [stf_pkg::CFG_W-1:0]         cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] bin_amplitude
    input  logic                              s_tlast,   // frame_end
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [19:0] trace_amplitude,
                                                         // [29:20] bin_number, [31:30] zero
    output logic                              m_tlast    // last_bin
);

    localparam int PW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CTL_W  = $bits(stf_pkg::item_ctl_t);
    localparam int ITEM_W = CTL_W + PW + stf_pkg::TRACE_W;

    logic                        q_push;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    stf_pkg::item_ctl_t          f_ctl;
    logic [PW-1:0]               f_pos;
    logic [stf_pkg::TRACE_W-1:0] f_fresh;
    logic [ITEM_W-1:0]           q_wdata;
    logic [ITEM_W-1:0]           q_rdata;
    stf_pkg::item_ctl_t          b_ctl;
    logic [PW-1:0]               b_pos;
    logic [stf_pkg::TRACE_W-1:0] b_fresh;
    logic [stf_pkg::TRACE_W-1:0] r_amp;
    logic [stf_pkg::BIN_W-1:0]   r_bin;

    stf_front #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_amp     (s_tdata),
        .s_last    (s_tlast),
        .q_room    (!q_full),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_pos     (f_pos),
        .q_fresh   (f_fresh)
    );

    assign q_wdata = {f_ctl, f_pos, f_fresh};

    stf_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign b_ctl   = q_rdata[ITEM_W-1 -: CTL_W];
    assign b_pos   = q_rdata[stf_pkg::TRACE_W +: PW];
    assign b_fresh = q_rdata[stf_pkg::TRACE_W-1:0];

    stf_back #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_empty),
        .q_pop   (q_pop),
        .q_ctl   (b_ctl),
        .q_pos   (b_pos),
        .q_fresh (b_fresh),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_amp   (r_amp),
        .m_bin   (r_bin),
        .m_last  (m_tlast)
    );

    assign m_tdata = {2'b00, r_bin, r_amp};

endmodule

/* src/stf_fifo.sv */
module stf_fifo #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* src/stf_front.sv */
module stf_front #(
    parameter int MAX_POINTS = 1024,
    parameter int PW         = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wen,
    input  logic [stf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [stf_pkg::CFG_W-1:0]           cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [stf_pkg::AMP_W-1:0]           s_amp,
    input  logic                                s_last,
    // queue side
    input  logic                                q_room,
    output logic                                q_push,
    output stf_pkg::item_ctl_t                  q_ctl,
    output logic [PW-1:0]                       q_pos,
    output logic [stf_pkg::TRACE_W-1:0]         q_fresh
);

    logic [2:0]                mode_reg;
    logic [stf_pkg::CFG_W-1:0] points_reg;
    logic [PW-1:0]             pos_reg;
    logic                      present_reg;
    logic [stf_pkg::DIV_W-1:0] frames_reg;

    logic                      accept;
    logic [31:0]               pts;
    logic [31:0]               pos_ext;
    logic [PW-1:0]             pos;
    logic                      last;
    logic [stf_pkg::DIV_W-1:0] divisor;
    stf_pkg::op_t              op;
    logic                      fill_done;
    logic                      avg_done;

    assign s_tready = q_room;
    assign accept   = s_tvalid && q_room;

    // Effective frame length: zero acts as one, capped at the store depth
    always_comb
    begin
        if (points_reg == '0)
        begin
            pts = 32'd1;
        end
        else if ({21'b0, points_reg} > 32'(MAX_POINTS))
        begin
            pts = 32'(MAX_POINTS);
        end
        else
        begin
            pts = {21'b0, points_reg};
        end
    end

    // Bin position and frame end
    always_comb
    begin
        pos_ext = 32'(pos_reg);
        pos     = (pos_ext >= pts) ? '0 : pos_reg;
        last    = s_last || ((32'(pos) + 32'd1) >= pts);
        divisor = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
    end

    // Classify the bin
    always_comb
    begin
        op        = stf_pkg::OP_PASS;
        fill_done = 1'b0;
        avg_done  = 1'b0;
        unique case (mode_reg)
            stf_pkg::MODE_CLEAR_WRITE:
            begin
                op        = stf_pkg::OP_WRITE;
                fill_done = last;
            end
            stf_pkg::MODE_MAX_HOLD,
            stf_pkg::MODE_MIN_HOLD,
            stf_pkg::MODE_AVERAGE:
            begin
                if (!present_reg)
                begin
                    op        = stf_pkg::OP_WRITE;
                    fill_done = last;
                end
                else if (mode_reg == stf_pkg::MODE_MAX_HOLD)
                begin
                    op = stf_pkg::OP_MAX;
                end
                else if (mode_reg == stf_pkg::MODE_MIN_HOLD)
                begin
                    op = stf_pkg::OP_MIN;
                end
                else
                begin
                    op       = stf_pkg::OP_AVG;
                    avg_done = last;
                end
            end
            default:
            begin
                // view and unused codes
                op = present_reg ? stf_pkg::OP_VIEW : stf_pkg::OP_PASS;
            end
        endcase
    end

    assign q_push        = accept;
    assign q_ctl.op      = op;
    assign q_ctl.last    = last;
    assign q_ctl.divisor = divisor;
    assign q_pos         = pos;
    assign q_fresh       = {s_amp, {stf_pkg::FRAC_W{1'b0}}};

    // Configuration and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= stf_pkg::MODE_CLEAR_WRITE;
            points_reg  <= 11'd1024;
            pos_reg     <= '0;
            present_reg <= 1'b0;
            frames_reg  <= '0;
        end
        else if (cfg_wen &&
                 (cfg_addr == stf_pkg::REG_TRACE_MODE || cfg_addr == stf_pkg::REG_POINTS))
        begin
            if (cfg_addr == stf_pkg::REG_TRACE_MODE)
            begin
                mode_reg <= cfg_wdata[2:0];
            end
            else
            begin
                points_reg <= cfg_wdata;
            end
            pos_reg     <= '0;
            present_reg <= 1'b0;
            frames_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg <= last ? '0 : pos + 1'b1;
            if (fill_done)
            begin
                present_reg <= 1'b1;
                frames_reg  <= stf_pkg::DIV_W'(1);
            end
            else if (avg_done)
            begin
                frames_reg <= divisor;
            end
        end
    end

endmodule

/* src/stf_back.sv */
module stf_back #(
    parameter int MAX_POINTS = 1024,
    parameter int PW         = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // queue side
    input  logic                            q_valid,
    output logic                            q_pop,
    input  stf_pkg::item_ctl_t              q_ctl,
    input  logic [PW-1:0]                   q_pos,
    input  logic [stf_pkg::TRACE_W-1:0]     q_fresh,
    // result stream
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [stf_pkg::TRACE_W-1:0]     m_amp,
    output logic [stf_pkg::BIN_W-1:0]       m_bin,
    output logic                            m_last
);

    localparam int CNT_W = $clog2(stf_pkg::NUM_W);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_FIN  = 2'd3;

    logic [stf_pkg::TRACE_W-1:0] trace_mem [MAX_POINTS];

    logic [1:0]                  state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    stf_pkg::item_ctl_t          ctl_reg;
    logic [PW-1:0]               pos_reg;
    logic [stf_pkg::TRACE_W-1:0] fresh_reg;
    logic [stf_pkg::TRACE_W-1:0] rdata_reg;
    logic [stf_pkg::TRACE_W-1:0] old_reg, old_next;
    logic [stf_pkg::TRACE_W-1:0] res_reg, res_next;
    logic                        neg_reg, neg_next;
    logic [stf_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [stf_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [stf_pkg::TRACE_W-1:0] out_amp_reg;
    logic [stf_pkg::BIN_W-1:0]   out_bin_reg;
    logic                        out_last_reg;

    logic                        mem_re;
    logic                        mem_we;
    logic                        load_out;
    logic [stf_pkg::NUM_W-1:0]   diff;
    logic [stf_pkg::NUM_W-1:0]   mag;
    logic [stf_pkg::DIV_W:0]     trial;
    logic                        qbit;
    logic [stf_pkg::TRACE_W-1:0] final_res;
    logic [PW+stf_pkg::BIN_W-1:0] pos_wide;

    assign m_valid = out_valid_reg;
    assign m_amp   = out_amp_reg;
    assign m_bin   = out_bin_reg;
    assign m_last  = out_last_reg;

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign mem_re   = q_pop;
    assign load_out = (state_reg == B_FIN) && (!out_valid_reg || m_ready);
    assign mem_we   = load_out && ctl_reg.op != stf_pkg::OP_VIEW
                               && ctl_reg.op != stf_pkg::OP_PASS;
    assign pos_wide = {{stf_pkg::BIN_W{1'b0}}, pos_reg};

    // Difference for the average step
    always_comb
    begin
        diff = {fresh_reg[stf_pkg::TRACE_W-1], fresh_reg}
             - {rdata_reg[stf_pkg::TRACE_W-1], rdata_reg};
        mag  = diff[stf_pkg::NUM_W-1] ? (~diff + 1'b1) : diff;
    end

    // One quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, num_reg[stf_pkg::NUM_W-1]};
        qbit  = (trial >= {1'b0, ctl_reg.divisor});
    end

    // Averaged value once the quotient is complete; other ops pass the read-step result
    always_comb
    begin
        if (ctl_reg.op == stf_pkg::OP_AVG)
        begin
            final_res = neg_reg ? old_reg - num_reg[stf_pkg::TRACE_W-1:0]
                                : old_reg + num_reg[stf_pkg::TRACE_W-1:0];
        end
        else
        begin
            final_res = res_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        old_next       = old_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                old_next   = rdata_reg;
                state_next = B_FIN;
                unique case (ctl_reg.op)
                    stf_pkg::OP_VIEW:
                    begin
                        res_next = rdata_reg;
                    end
                    stf_pkg::OP_MAX:
                    begin
                        res_next = ($signed(fresh_reg) > $signed(rdata_reg)) ? fresh_reg
                                                                            : rdata_reg;
                    end
                    stf_pkg::OP_MIN:
                    begin
                        res_next = ($signed(fresh_reg) < $signed(rdata_reg)) ? fresh_reg
                                                                            : rdata_reg;
                    end
                    stf_pkg::OP_AVG:
                    begin
                        neg_next   = diff[stf_pkg::NUM_W-1];
                        num_next   = mag + stf_pkg::NUM_W'(ctl_reg.divisor[stf_pkg::DIV_W-1:1]);
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = B_DIV;
                    end
                    default:
                    begin
                        res_next = fresh_reg;
                    end
                endcase
            end
            B_DIV:
            begin
                rem_next = qbit ? stf_pkg::DIV_W'(trial - {1'b0, ctl_reg.divisor})
                                : trial[stf_pkg::DIV_W-1:0];
                num_next = {num_reg[stf_pkg::NUM_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(stf_pkg::NUM_W - 1))
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        old_reg <= old_next;
        res_reg <= res_next;
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (q_pop)
        begin
            ctl_reg   <= q_ctl;
            pos_reg   <= q_pos;
            fresh_reg <= q_fresh;
        end
        if (load_out)
        begin
            out_amp_reg  <= final_res;
            out_bin_reg  <= pos_wide[stf_pkg::BIN_W-1:0];
            out_last_reg <= ctl_reg.last;
        end
    end

    // Trace store
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= trace_mem[q_pos];
        end
        if (mem_we)
        begin
            trace_mem[pos_reg] <= final_res;
        end
    end

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> state_reg == B_IDLE && out_valid_reg)
        else $error("result not delivered after finish");

    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_READ |=> state_reg == B_FIN || state_reg == B_DIV)
        else $error("read step not followed by divide or finish");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> cnt_reg <= CNT_W'(stf_pkg::NUM_W - 1))
        else $error("divider ran past its last step");

    a_div_op: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> ctl_reg.op == stf_pkg::OP_AVG && ctl_reg.divisor != '0)
        else $error("divider busy outside an average step");

endmodule

/* test/spectrum_trace_accumulator_tb.sv */
module spectrum_trace_accumulator_tb;

    localparam int MAX_BINS = 1024;
    localparam int RANDOM_BINS = 650;
    localparam int SETTLE_CYCLES = 30;
    // Register index past the list, written to check it is ignored
    localparam logic [stf_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    // Mode codes past the list, treated as view
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [stf_pkg::AMP_W-1:0] amp;
        logic                      fend;
    } bin_item_t;

    typedef struct {
        logic signed [stf_pkg::TRACE_W-1:0] amp;
        logic [stf_pkg::BIN_W-1:0]          bin;
        logic                               last;
    } trace_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wen = 1'b0;
    logic [stf_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [stf_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;   // [15:0] bin_amplitude
    logic                           s_tlast = 1'b0; // frame_end
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;        // [19:0] trace_amplitude, [29:20] bin_number
    logic                           m_tlast;        // last_bin

    spectrum_trace_accumulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // Stimulus and expectation queues
    bin_item_t     pending_bins[$];
    trace_result_t expected_trace[$];
    bin_item_t     bin_on_bus;
    trace_result_t want_res;
    trace_result_t got_res;

    // Predictor state
    logic signed [stf_pkg::TRACE_W-1:0] trace_mem [0:MAX_BINS-1];
    logic                               trace_valid = 1'b0;
    logic [stf_pkg::DIV_W-1:0]          frame_count = '0;
    int                                 next_bin = 0;
    logic [2:0]                         cur_mode = stf_pkg::MODE_CLEAR_WRITE;
    logic [stf_pkg::CFG_W-1:0]          cur_points = 11'd1024;

    // Bookkeeping
    bit calm = 1'b1;
    int send_wait = 0;
    int recv_wait = 0;
    int bins_queued = 0;
    int bins_sent = 0;
    int results_seen = 0;
    int fail_count = 0;
    int phases_run = 0;
    int deepest_divisor = 0;

    function automatic int active_points(input logic [stf_pkg::CFG_W-1:0] p);
        if (p == 0)
            return 1;
        if (p > MAX_BINS)
            return MAX_BINS;
        return int'(p);
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Work out the trace result of one accepted bin
    task automatic predict_trace(input bin_item_t b);
        int pts;
        int pos;
        int divisor;
        int diff;
        int mag;
        int quot;
        logic signed [stf_pkg::TRACE_W-1:0] fresh;
        logic signed [stf_pkg::TRACE_W-1:0] old;
        logic signed [stf_pkg::TRACE_W-1:0] res;
        logic last;
        trace_result_t r;
        pts = active_points(cur_points);
        pos = next_bin;
        if (pos >= pts)
            pos = 0;
        fresh = {b.amp, 4'b0000};
        last = b.fend || (pos + 1 >= pts);
        divisor = int'(frame_count) + 1;
        if (divisor > 65535)
            divisor = 65535;
        case (cur_mode)
            stf_pkg::MODE_CLEAR_WRITE:
            begin
                trace_mem[pos] = fresh;
                res = fresh;
                if (last)
                begin
                    trace_valid = 1'b1;
                    frame_count = 16'd1;
                end
            end
            stf_pkg::MODE_MAX_HOLD, stf_pkg::MODE_MIN_HOLD, stf_pkg::MODE_AVERAGE:
            begin
                if (!trace_valid)
                begin
                    // first frame only fills the store
                    trace_mem[pos] = fresh;
                    res = fresh;
                    if (last)
                    begin
                        trace_valid = 1'b1;
                        frame_count = 16'd1;
                    end
                end
                else
                begin
                    old = trace_mem[pos];
                    if (cur_mode == stf_pkg::MODE_MAX_HOLD)
                    begin
                        if (fresh > old)
                            old = fresh;
                    end
                    else if (cur_mode == stf_pkg::MODE_MIN_HOLD)
                    begin
                        if (fresh < old)
                            old = fresh;
                    end
                    else
                    begin
                        // round to nearest, halves away from zero
                        diff = int'(fresh) - int'(old);
                        mag = (diff < 0) ? -diff : diff;
                        quot = (mag + divisor / 2) / divisor;
                        old = stf_pkg::TRACE_W'((diff < 0) ? int'(old) - quot
                                                          : int'(old) + quot);
                        if (divisor > deepest_divisor)
                            deepest_divisor = divisor;
                        if (last)
                            frame_count = 16'(divisor);
                    end
                    trace_mem[pos] = old;
                    res = old;
                end
            end
            default:
                res = trace_valid ? trace_mem[pos] : fresh;
        endcase
        next_bin = last ? 0 : pos + 1;
        r.amp = res;
        r.bin = 10'(pos);
        r.last = last;
        expected_trace.push_back(r);
    endtask

    // Register write; the predictor follows at once since the block is idle
    task automatic write_reg(input logic [stf_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [stf_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == stf_pkg::REG_TRACE_MODE || idx == stf_pkg::REG_POINTS)
        begin
            if (idx == stf_pkg::REG_TRACE_MODE)
                cur_mode = val[2:0];
            else
                cur_points = val;
            trace_valid = 1'b0;
            frame_count = '0;
            next_bin = 0;
        end
    endtask

    task automatic set_config(input logic [2:0] mode, input logic [stf_pkg::CFG_W-1:0] points);
        if ($urandom_range(0, 1))
        begin
            write_reg(stf_pkg::REG_TRACE_MODE, stf_pkg::CFG_W'(mode));
            write_reg(stf_pkg::REG_POINTS, points);
        end
        else
        begin
            write_reg(stf_pkg::REG_POINTS, points);
            write_reg(stf_pkg::REG_TRACE_MODE, stf_pkg::CFG_W'(mode));
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic push_bin(input logic [stf_pkg::AMP_W-1:0] amp, input logic fend);
        bin_item_t b;
        b.amp = amp;
        b.fend = fend;
        pending_bins.push_back(b);
        bins_queued++;
    endtask

    // Random bins; in hold and average modes the first frame covers every point
    // so later frames never read an entry that was not written
    task automatic queue_bins(input logic [2:0] mode, input logic [stf_pkg::CFG_W-1:0] points,
                              input int n_bins, input bit fill_first);
        int pts;
        bit filling;
        pts = active_points(points);
        filling = fill_first &&
                  (mode == stf_pkg::MODE_MAX_HOLD || mode == stf_pkg::MODE_MIN_HOLD ||
                   mode == stf_pkg::MODE_AVERAGE);
        for (int k = 0; k < n_bins; k++)
        begin
            if (filling && k < pts)
                push_bin(16'($urandom_range(0, 16'hFFFF)),
                         (k == pts - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
            else
                push_bin(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 5) == 0);
        end
    endtask

    // Wait until every queued bin has produced its result, then let the block settle
    task automatic drain_all();
        while (results_seen < bins_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [2:0] mode, input logic [stf_pkg::CFG_W-1:0] points,
                             input int n_bins);
        set_config(mode, points);
        queue_bins(mode, points, n_bins, 1'b1);
        drain_all();
        phases_run++;
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_trace(bin_on_bus);
                bins_sent++;
                send_wait = draw_wait();
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bins.size() > 0)
                begin
                    bin_on_bus = pending_bins.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= bin_on_bus.amp;
                    s_tlast <= bin_on_bus.fend;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got_res.amp = m_tdata[stf_pkg::TRACE_W-1:0];
                got_res.bin = m_tdata[29:20];
                got_res.last = m_tlast;
                if (expected_trace.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result amp %0d bin %0d last %0b", $time,
                                 got_res.amp, got_res.bin, got_res.last);
                end
                else
                begin
                    want_res = expected_trace.pop_front();
                    if (got_res.amp !== want_res.amp || got_res.bin !== want_res.bin ||
                        got_res.last !== want_res.last || m_tdata[31:30] !== 2'b00)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: exp %0d/%0d/%0b act %0d/%0d/%0b pad %b", $time,
                                     want_res.amp, want_res.bin, want_res.last,
                                     got_res.amp, got_res.bin, got_res.last, m_tdata[31:30]);
                    end
                end
                recv_wait = draw_wait();
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Run watchdog
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence
    initial
    begin
        int rand_start;
        int sel;
        int psel;
        logic [2:0] mode;
        logic [stf_pkg::CFG_W-1:0] points;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: clear write over 1024 points, amplitude extremes
        calm = 1'b1;
        push_bin(16'h8000, 1'b0);
        push_bin(16'h7FFF, 1'b0);
        push_bin(16'h0000, 1'b1);
        push_bin(16'hFFFF, 1'b0);
        push_bin(16'h5555, 1'b0);
        push_bin(16'hAAAA, 1'b1);
        drain_all();
        phases_run++;

        // View with nothing stored passes the input
        set_config(stf_pkg::MODE_VIEW, 11'd3);
        push_bin(16'h1234, 1'b0);
        push_bin(16'hFEDC, 1'b1);
        drain_all();

        // Spare mode codes behave as view
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
        begin
            set_config(3'(m), 11'd2);
            push_bin(16'($urandom_range(0, 16'hFFFF)), 1'b0);
            drain_all();
        end

        // Max hold: fill frame, compare frame, early frame end at bin zero
        set_config(stf_pkg::MODE_MAX_HOLD, 11'd2);
        push_bin(16'h0064, 1'b0);
        push_bin(16'hFFFB, 1'b0);
        push_bin(16'h00C8, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h7FFF, 1'b1);
        drain_all();

        // Min hold, same pattern
        set_config(stf_pkg::MODE_MIN_HOLD, 11'd2);
        push_bin(16'h0064, 1'b0);
        push_bin(16'hFFFB, 1'b0);
        push_bin(16'h00C8, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h8000, 1'b1);
        drain_all();

        // Average across full-scale swings
        set_config(stf_pkg::MODE_AVERAGE, 11'd2);
        push_bin(16'h7FFF, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h7FFF, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h7FFF, 1'b0);
        drain_all();
        phases_run += 7;

        // Random phases, mostly hold and average over small frames
        rand_start = bins_queued;
        while (bins_queued - rand_start < RANDOM_BINS)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: mode = stf_pkg::MODE_CLEAR_WRITE;
                1: mode = stf_pkg::MODE_VIEW;
                2, 3: mode = stf_pkg::MODE_MAX_HOLD;
                4, 5: mode = stf_pkg::MODE_MIN_HOLD;
                6, 7, 8: mode = stf_pkg::MODE_AVERAGE;
                default: mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            endcase
            psel = $urandom_range(0, 9);
            case (psel)
                0: points = 11'd0;
                1: points = 11'd1;
                2: points = 11'd2;
                default: points = 11'($urandom_range(3, 24));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            run_phase(mode, points, active_points(points) + $urandom_range(16, 48));
        end

        // Oversized point count acts as the store depth
        calm = 1'b1;
        set_config(stf_pkg::MODE_CLEAR_WRITE, 11'd2047);
        for (int k = 0; k < 40; k++)
            push_bin(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 7) == 0);
        drain_all();
        phases_run++;

        // Long single-point average; a write past the register list must not clear it
        calm = 1'b0;
        run_phase(stf_pkg::MODE_AVERAGE, 11'd1, 90);
        write_reg(REG_UNUSED, 11'($urandom_range(0, 11'h7FF)));
        @(posedge clk);
        cfg_wen <= 1'b0;
        queue_bins(stf_pkg::MODE_AVERAGE, 11'd1, 90, 1'b0);
        drain_all();

        $display("Run covered %0d bins over %0d settings: clear write, view, spare modes,",
                 bins_sent, phases_run);
        $display("max/min hold and average up to divisor %0d; %0d results, %0d failures.",
                 deepest_divisor, results_seen, fail_count);
        if (fail_count == 0 && expected_trace.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
